>>> rtl/phv_pkg.sv
package phv_pkg;

  localparam int SCORE_W = 31;
  localparam int WIDE_W = 34;
  localparam int NMOVES = 9;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam score_t POS_INF = 31'sd987654321;
  localparam score_t NEG_INF = -31'sd987654321;

  localparam logic [1:0] REQ_TRANS = 2'd0;
  localparam logic [1:0] REQ_EMIT = 2'd1;
  localparam logic [1:0] REQ_SPEC = 2'd2;
  localparam logic [1:0] REQ_RES = 2'd3;

  localparam int T_MM = 0;
  localparam int T_MI = 1;
  localparam int T_MD = 2;
  localparam int T_IM = 3;
  localparam int T_II = 4;
  localparam int T_DM = 5;
  localparam int T_DD = 6;
  localparam int T_B = 7;
  localparam int T_E = 8;

  localparam int E_MATCH = 0;
  localparam int E_INS = 1;

  localparam int SP_NMOVE = 0;
  localparam int SP_NLOOP = 1;
  localparam int SP_EMOVE = 2;
  localparam int SP_ELOOP = 3;
  localparam int SP_CMOVE = 4;
  localparam int SP_CLOOP = 5;
  localparam int SP_JMOVE = 6;
  localparam int SP_JLOOP = 7;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic issue_last;
    logic fin1;
    logic fin2;
    logic emit;
  } phv_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic out_busy;
  } phv_stat_t;

  function automatic wide_t ext(score_t s);
    return wide_t'(s);
  endfunction

  function automatic wide_t wmax(wide_t a, wide_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic score_t sat(wide_t v);
    if (v < ext(NEG_INF)) return NEG_INF;
    if (v > ext(POS_INF)) return POS_INF;
    return score_t'(v);
  endfunction

endpackage

>>> rtl/profile_hmm_viterbi_score.sv
// channel   direction  handshake              payload
// in_       slave      in_tvalid/in_tready    tdata, tuser = req_type, tlast = last
// out_      master     out_tvalid/out_tready  tdata = score
// cfg_      apb        psel/penable/pready    model_length at byte address 0
//
// a load request is written at the accept edge
// a residue request goes from its accept through the node reads for nodes 0 to M,
// the node pipeline drain, a step to see the sweep end and two steps for the
// special states before the next accept
// synchronous active-low reset, no clearing pass, tables are loaded by requests
// a last residue with a pending unread result waits before its own result is stored
module profile_hmm_viterbi_score import phv_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int SYMBOLS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // node[10:0], slot[14:11], symbol[19:15], score_value[50:20], first[51]
  input  logic [55:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // score[30:0]
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NW = $clog2(MAX_NODES + 1);

  logic [10:0] model_length_r;
  phv_cmd_t cmd;
  phv_stat_t stat;
  logic [NW-1:0] issue_addr;
  logic in_ready_c;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {21'd0, model_length_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_length_r <= 11'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      model_length_r <= cfg_pwdata[10:0];
    end
  end

  assign in_tready = in_ready_c;

  phv_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_ready_c),
    .in_type      (in_tuser),
    .in_last      (in_tlast),
    .model_length (model_length_r),
    .stat         (stat),
    .cmd          (cmd),
    .issue_addr   (issue_addr)
  );

  phv_dp #(.MAX_NODES(MAX_NODES), .SYMBOLS(SYMBOLS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .issue_addr (issue_addr),
    .in_type    (in_tuser),
    .in_node    (in_tdata[10:0]),
    .in_slot    (in_tdata[14:11]),
    .in_symbol  (in_tdata[19:15]),
    .in_score   (score_t'(in_tdata[50:20])),
    .in_first   (in_tdata[51]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/phv_ctrl.sv
module phv_ctrl import phv_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [1:0]                          in_type,
  input  logic                                in_last,
  input  logic [10:0]                         model_length,
  input  phv_stat_t                           stat,
  output phv_cmd_t                            cmd,
  output logic [$clog2(MAX_NODES+1)-1:0]      issue_addr
);

  localparam int NW = $clog2(MAX_NODES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FIN1 = 3'd3;
  localparam logic [2:0] S_FIN2 = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [NW-1:0] j_r, j_nxt;
  logic [NW-1:0] m_r, m_nxt;
  logic last_r, last_nxt;
  logic [NW-1:0] m_c;

  always_comb begin
    if (model_length == 11'd0) begin
      m_c = NW'(1);
    end else if (32'(model_length) > MAX_NODES) begin
      m_c = NW'(MAX_NODES);
    end else begin
      m_c = NW'(model_length);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign issue_addr = j_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    j_nxt = j_r;
    m_nxt = m_r;
    last_nxt = last_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_type == REQ_RES) begin
            cmd.start = 1'b1;
            state_nxt = S_SWEEP;
            j_nxt = '0;
            m_nxt = m_c;
            last_nxt = in_last;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SWEEP: begin
        cmd.issue = 1'b1;
        cmd.issue_last = (j_r == m_r);
        if (j_r == m_r) begin
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + NW'(1);
        end
      end
      S_DRAIN: begin
        if (stat.sweep_done) begin
          state_nxt = S_FIN1;
        end
      end
      S_FIN1: begin
        cmd.fin1 = 1'b1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        if (!(last_r && stat.out_busy)) begin
          cmd.fin2 = 1'b1;
          cmd.emit = last_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r <= '0;
      m_r <= NW'(1);
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r <= j_nxt;
      m_r <= m_nxt;
      last_r <= last_nxt;
    end
  end

endmodule

>>> rtl/phv_dp.sv
module phv_dp import phv_pkg::*; #(
  parameter int MAX_NODES = 1024,
  parameter int SYMBOLS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  phv_cmd_t                            cmd,
  output phv_stat_t                           stat,
  input  logic [$clog2(MAX_NODES+1)-1:0]      issue_addr,
  input  logic [1:0]                          in_type,
  input  logic [10:0]                         in_node,
  input  logic [3:0]                          in_slot,
  input  logic [4:0]                          in_symbol,
  input  score_t                              in_score,
  input  logic                                in_first,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata
);

  localparam int NODES = MAX_NODES + 1;
  localparam int NW = $clog2(NODES);
  localparam int EW = $clog2(SYMBOLS * NODES);

  logic [NMOVES-1:0][SCORE_W-1:0] tt_mem [NODES];
  logic [1:0][SCORE_W-1:0] em_mem [SYMBOLS*NODES];
  logic [2:0][SCORE_W-1:0] row_mem [NODES];

  logic [NMOVES-1:0][SCORE_W-1:0] tt_q_r;
  logic [1:0][SCORE_W-1:0] em_q_r;
  logic [2:0][SCORE_W-1:0] row_q_r;

  score_t sp_r [8];
  score_t sr_n_r, sr_b_r, sr_c_r, sr_j_r;
  logic first_r, sym_bad_r;
  logic [EW-1:0] e_base_r;

  logic node_ok, sym_ok;
  logic [NW-1:0] ld_node;
  logic [EW-1:0] ld_eaddr, rd_eaddr;

  assign node_ok = (32'(in_node) <= MAX_NODES);
  assign sym_ok = (32'(in_symbol) < SYMBOLS);
  assign ld_node = NW'(in_node);
  assign ld_eaddr = EW'(in_symbol) * EW'(NODES) + EW'(in_node);
  assign rd_eaddr = e_base_r + EW'(issue_addr);

  always_ff @(posedge clk) begin
    if (cmd.load && in_type == REQ_TRANS && node_ok && in_slot < 4'(NMOVES)) begin
      tt_mem[ld_node][in_slot] <= in_score;
    end
    if (cmd.load && in_type == REQ_EMIT && node_ok && in_slot < 4'd2 && sym_ok) begin
      em_mem[ld_eaddr][in_slot[0]] <= in_score;
    end
    if (cmd.issue) begin
      tt_q_r <= tt_mem[issue_addr];
      em_q_r <= em_mem[rd_eaddr];
      row_q_r <= row_mem[issue_addr];
    end
  end

  // special score loading, residue setup and special states
  score_t ec_c, jj_c, cc_c, nn_c, bb_c, fin_c;
  score_t jj_t_r, cc_t_r, nn_t_r, out_data_r;
  wide_t e_r;

  always_comb begin
    ec_c = sat(e_r);
    jj_c = sat(wmax(ext(sr_j_r) + ext(sp_r[SP_JLOOP]), ext(ec_c) + ext(sp_r[SP_ELOOP])));
    cc_c = sat(wmax(ext(sr_c_r) + ext(sp_r[SP_CLOOP]), ext(ec_c) + ext(sp_r[SP_EMOVE])));
    nn_c = sat(ext(sr_n_r) + ext(sp_r[SP_NLOOP]));
    bb_c = sat(wmax(ext(nn_t_r) + ext(sp_r[SP_NMOVE]), ext(jj_t_r) + ext(sp_r[SP_JMOVE])));
    fin_c = sat(ext(cc_t_r) + ext(sp_r[SP_CMOVE]));
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_type == REQ_SPEC && in_slot < 4'd8) begin
      sp_r[in_slot[2:0]] <= in_score;
    end
    if (cmd.start) begin
      first_r <= in_first;
      sym_bad_r <= !sym_ok;
      e_base_r <= EW'(in_symbol) * EW'(NODES);
      if (in_first) begin
        sr_n_r <= '0;
        sr_b_r <= sat(ext(sp_r[SP_NMOVE]));
        sr_c_r <= NEG_INF;
        sr_j_r <= NEG_INF;
      end
    end
    if (cmd.fin1) begin
      jj_t_r <= jj_c;
      cc_t_r <= cc_c;
      nn_t_r <= nn_c;
    end
    if (cmd.fin2) begin
      sr_n_r <= nn_t_r;
      sr_b_r <= bb_c;
      sr_c_r <= cc_t_r;
      sr_j_r <= jj_t_r;
    end
    if (cmd.emit) begin
      out_data_r <= fin_c;
    end
  end

  // node pipeline: read, sums, states, row write
  logic p1_v_r, p1_k0_r, p1_last_r;
  logic [NW-1:0] p1_addr_r;
  score_t tmm_p_r, tim_p_r, tdm_p_r, tmd_p_r, tdd_p_r;
  score_t omp_r, oip_r, odp_r;
  score_t om_o, oi_o, od_o;
  wide_t sa_c, sb_c, si_c;

  logic s2_v_r, s2_last_r;
  logic [NW-1:0] s2_addr_r;
  wide_t sa_r, sb_r, si_r;
  score_t em_m_r, em_i_r, t8_r, t2_r, t6_r;

  score_t nm_c, ni_c, nd_c;
  logic w_v_r, w_last_r, done_r;
  logic [NW-1:0] w_addr_r;
  score_t nm_r, ni_r, nd_r, t8w_r;

  always_comb begin
    om_o = first_r ? NEG_INF : score_t'(row_q_r[0]);
    oi_o = first_r ? NEG_INF : score_t'(row_q_r[1]);
    od_o = first_r ? NEG_INF : score_t'(row_q_r[2]);
    sa_c = wmax(ext(omp_r) + ext(tmm_p_r), ext(oip_r) + ext(tim_p_r));
    sb_c = wmax(ext(odp_r) + ext(tdm_p_r), ext(sr_b_r) + ext(score_t'(tt_q_r[T_B])));
    si_c = wmax(ext(om_o) + ext(score_t'(tt_q_r[T_MI])),
                ext(oi_o) + ext(score_t'(tt_q_r[T_II])));
    nm_c = sat(wmax(sa_r, sb_r) + ext(em_m_r));
    ni_c = s2_last_r ? NEG_INF : sat(si_r + ext(em_i_r));
    nd_c = s2_last_r ? NEG_INF :
           sat(wmax(ext(nm_r) + ext(t2_r), ext(nd_r) + ext(t6_r)));
  end

  always_ff @(posedge clk) begin
    if (w_v_r) begin
      row_mem[w_addr_r] <= {nd_r, ni_r, nm_r};
    end
    p1_k0_r <= (issue_addr == '0);
    p1_last_r <= cmd.issue_last;
    p1_addr_r <= issue_addr;
    if (p1_v_r) begin
      tmm_p_r <= score_t'(tt_q_r[T_MM]);
      tim_p_r <= score_t'(tt_q_r[T_IM]);
      tdm_p_r <= score_t'(tt_q_r[T_DM]);
      tmd_p_r <= score_t'(tt_q_r[T_MD]);
      tdd_p_r <= score_t'(tt_q_r[T_DD]);
      if (p1_k0_r) begin
        omp_r <= NEG_INF;
        oip_r <= NEG_INF;
        odp_r <= NEG_INF;
      end else begin
        omp_r <= om_o;
        oip_r <= oi_o;
        odp_r <= od_o;
      end
      sa_r <= sa_c;
      sb_r <= sb_c;
      si_r <= si_c;
      em_m_r <= sym_bad_r ? NEG_INF : score_t'(em_q_r[E_MATCH]);
      em_i_r <= sym_bad_r ? NEG_INF : score_t'(em_q_r[E_INS]);
      t8_r <= score_t'(tt_q_r[T_E]);
      t2_r <= tmd_p_r;
      t6_r <= tdd_p_r;
      s2_last_r <= p1_last_r;
      s2_addr_r <= p1_addr_r;
    end
    if (cmd.start) begin
      nm_r <= NEG_INF;
      nd_r <= NEG_INF;
      e_r <= ext(NEG_INF);
    end else begin
      if (s2_v_r) begin
        nm_r <= nm_c;
        ni_r <= ni_c;
        nd_r <= nd_c;
        t8w_r <= t8_r;
        w_addr_r <= s2_addr_r;
        w_last_r <= s2_last_r;
      end
      if (w_v_r) begin
        e_r <= wmax(e_r, ext(nm_r) + ext(t8w_r));
      end
    end
  end

  logic out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      w_v_r <= 1'b0;
      done_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.issue;
      s2_v_r <= p1_v_r && !p1_k0_r;
      w_v_r <= s2_v_r;
      done_r <= w_v_r && w_last_r;
      if (cmd.emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign stat.sweep_done = done_r;
  assign stat.out_busy = out_v_r && !out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata = {1'b0, out_data_r};

endmodule
